>>> rtl/grey_mean_std_normalizer_macros.svh
// Assertion macros for the grey mean/std normalizer.
// Used by the controller and the pixel pipeline; no other dependencies.
`ifndef GREY_MEAN_STD_NORMALIZER_MACROS_SVH
`define GREY_MEAN_STD_NORMALIZER_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, clocked on clk, off during reset
`define GMSN_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gmsn: same-cycle check failed");
// next-cycle implication, clocked on clk, off during reset
`define GMSN_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gmsn: next-cycle check failed");
`else
`define GMSN_ASSERT_NOW(label, ante, cons)
`define GMSN_ASSERT_NEXT(label, ante, cons)
`endif
`endif

>>> rtl/gmsn_pkg.sv
// Shared types and constants for the grey mean/std normalizer.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
package gmsn_pkg;

  // Pixel counting
  localparam int CNT_W = 22;
  localparam logic [CNT_W:0] FRAME_PIXELS = 23'd2097152;

  // Statistic widths
  localparam int SUM_W  = 29;
  localparam int SQ_W   = 37;
  localparam int MEAN_W = 16;
  localparam int INV_W  = 24;

  // Pass kinds carried in the kind field
  localparam logic PASS_GATHER    = 1'b0;
  localparam logic PASS_NORMALIZE = 1'b1;

  // Grey weights, Q16
  localparam int W0 = 19661;
  localparam int W1 = 38666;
  localparam int W2 = 7209;

  // Iterative unit widths and step counts
  localparam int QUO_W      = 40;
  localparam int DVS_W      = 32;
  localparam int PROD_W     = 59;
  localparam int MPL_W      = 29;
  localparam int RAD_W      = 63;
  localparam int DIV_STEPS  = 40;
  localparam int MUL_STEPS  = 29;
  localparam int ROOT_STEPS = 32;
  localparam int STEP_W     = 6;

  typedef struct packed {
    logic       kind;
    logic [7:0] chan0;
    logic [7:0] chan1;
    logic [7:0] chan2;
    logic       frame_end;
  } in_pkt_t;

  typedef struct packed {
    logic [7:0] norm_pixel;
    logic       is_last;
  } out_pkt_t;

  typedef enum logic [3:0] {
    ST_RUN,
    ST_FOLD,
    ST_MEAN_LD,
    ST_MEAN_DIV,
    ST_MEAN_WR,
    ST_MULA_LD,
    ST_MULA_RUN,
    ST_MULB_LD,
    ST_MULB_RUN,
    ST_ROOT_LD,
    ST_ROOT_RUN,
    ST_INV_LD,
    ST_INV_DIV,
    ST_INV_WR
  } state_t;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_DIV_MEAN_LD,
    OP_DIV_STEP,
    OP_MEAN_WR,
    OP_MULA_LD,
    OP_MUL_STEP,
    OP_MULB_LD,
    OP_ROOT_LD,
    OP_ROOT_STEP,
    OP_DIV_INV_LD,
    OP_INV_WR
  } stats_op_t;

  // controller -> datapath commands
  typedef struct packed {
    stats_op_t op;
    logic      clear_sums;
  } ctrl_cmd_t;

  // pixel pipeline -> controller status
  typedef struct packed {
    logic s1_ready;
    logic gather_last;
  } pipe_sts_t;

endpackage

>>> rtl/gmsn_stats.sv
// Frame statistics unit: shared-in-time divider, shift-add multiplier and
// bit-pair square root, stepped by controller commands. Uses gmsn_pkg.
`timescale 1ns / 1ps
module gmsn_stats (
  input  logic                          clk,
  input  logic                          rst_n,
  input  gmsn_pkg::ctrl_cmd_t           cmd,
  input  logic [gmsn_pkg::SUM_W-1:0]    grey_sum,
  input  logic [gmsn_pkg::SQ_W-1:0]     square_sum,
  input  logic [gmsn_pkg::CNT_W-1:0]    fin_n,
  output logic [gmsn_pkg::MEAN_W-1:0]   mean_q8,
  output logic [gmsn_pkg::INV_W-1:0]    inv_std_q16
);

  // divider
  logic [gmsn_pkg::QUO_W-1:0]  quo_r, quo_nxt;
  logic [gmsn_pkg::DVS_W-1:0]  rem_r, rem_nxt;
  logic [gmsn_pkg::DVS_W-1:0]  dvs_r, dvs_nxt;
  logic [gmsn_pkg::DVS_W:0]    trial, trial_sub;
  // multiplier
  logic [gmsn_pkg::PROD_W-1:0] mcand_r, mcand_nxt;
  logic [gmsn_pkg::MPL_W-1:0]  mplier_r, mplier_nxt;
  logic [gmsn_pkg::PROD_W-1:0] prod_r, prod_nxt;
  logic [gmsn_pkg::PROD_W-1:0] a_r, a_nxt;
  logic [gmsn_pkg::PROD_W-1:0] dev;
  // square root
  logic [gmsn_pkg::RAD_W-1:0]  rad_r, rad_nxt;
  logic [gmsn_pkg::RAD_W-1:0]  res_r, res_nxt;
  logic [gmsn_pkg::RAD_W-1:0]  bit_r, bit_nxt;
  logic [gmsn_pkg::RAD_W:0]    root_try;
  // results
  logic [gmsn_pkg::MEAN_W-1:0] mean_r, mean_nxt;
  logic [gmsn_pkg::INV_W-1:0]  inv_r, inv_nxt;

  // one restoring division step
  assign trial     = {rem_r, quo_r[gmsn_pkg::QUO_W-1]};
  assign trial_sub = trial - {1'b0, dvs_r};

  // count*sum_sq - sum^2, floored at zero
  assign dev = (a_r > prod_r) ? (a_r - prod_r) : '0;

  // radicand test value res + bit
  assign root_try = {1'b0, res_r} + {1'b0, bit_r};

  // step logic
  always_comb begin
    quo_nxt    = quo_r;
    rem_nxt    = rem_r;
    dvs_nxt    = dvs_r;
    mcand_nxt  = mcand_r;
    mplier_nxt = mplier_r;
    prod_nxt   = prod_r;
    a_nxt      = a_r;
    rad_nxt    = rad_r;
    res_nxt    = res_r;
    bit_nxt    = bit_r;
    mean_nxt   = mean_r;
    inv_nxt    = inv_r;
    case (cmd.op)
      gmsn_pkg::OP_DIV_MEAN_LD: begin
        quo_nxt = {3'b000, grey_sum, 8'h00};
        rem_nxt = '0;
        dvs_nxt = {10'd0, fin_n};
      end
      gmsn_pkg::OP_DIV_STEP: begin
        if (trial >= {1'b0, dvs_r}) begin
          rem_nxt = trial_sub[gmsn_pkg::DVS_W-1:0];
          quo_nxt = {quo_r[gmsn_pkg::QUO_W-2:0], 1'b1};
        end else begin
          rem_nxt = trial[gmsn_pkg::DVS_W-1:0];
          quo_nxt = {quo_r[gmsn_pkg::QUO_W-2:0], 1'b0};
        end
      end
      gmsn_pkg::OP_MEAN_WR: begin
        mean_nxt = quo_r[gmsn_pkg::MEAN_W-1:0];
      end
      gmsn_pkg::OP_MULA_LD: begin
        mcand_nxt  = {22'd0, square_sum};
        mplier_nxt = {7'd0, fin_n};
        prod_nxt   = '0;
      end
      gmsn_pkg::OP_MUL_STEP: begin
        if (mplier_r[0]) begin
          prod_nxt = prod_r + mcand_r;
        end
        mcand_nxt  = {mcand_r[gmsn_pkg::PROD_W-2:0], 1'b0};
        mplier_nxt = {1'b0, mplier_r[gmsn_pkg::MPL_W-1:1]};
      end
      gmsn_pkg::OP_MULB_LD: begin
        a_nxt      = prod_r;
        mcand_nxt  = {30'd0, grey_sum};
        mplier_nxt = grey_sum;
        prod_nxt   = '0;
      end
      gmsn_pkg::OP_ROOT_LD: begin
        rad_nxt = {dev, 4'h0};
        res_nxt = '0;
        bit_nxt = {1'b1, {(gmsn_pkg::RAD_W-1){1'b0}}};
      end
      gmsn_pkg::OP_ROOT_STEP: begin
        if ({1'b0, rad_r} >= root_try) begin
          rad_nxt = rad_r - root_try[gmsn_pkg::RAD_W-1:0];
          res_nxt = {1'b0, res_r[gmsn_pkg::RAD_W-1:1]} + bit_r;
        end else begin
          res_nxt = {1'b0, res_r[gmsn_pkg::RAD_W-1:1]};
        end
        bit_nxt = {2'b00, bit_r[gmsn_pkg::RAD_W-1:2]};
      end
      gmsn_pkg::OP_DIV_INV_LD: begin
        quo_nxt = {fin_n, 18'd0};
        rem_nxt = '0;
        dvs_nxt = res_r[gmsn_pkg::DVS_W-1:0];
      end
      gmsn_pkg::OP_INV_WR: begin
        // zero deviation gives zero; large reciprocals saturate
        if (res_r == '0) begin
          inv_nxt = '0;
        end else if (|quo_r[gmsn_pkg::QUO_W-1:gmsn_pkg::INV_W]) begin
          inv_nxt = '1;
        end else begin
          inv_nxt = quo_r[gmsn_pkg::INV_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  // working registers
  always_ff @(posedge clk) begin
    quo_r    <= quo_nxt;
    rem_r    <= rem_nxt;
    dvs_r    <= dvs_nxt;
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
    prod_r   <= prod_nxt;
    a_r      <= a_nxt;
    rad_r    <= rad_nxt;
    res_r    <= res_nxt;
    bit_r    <= bit_nxt;
  end

  // frame statistics
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mean_r <= '0;
      inv_r  <= '0;
    end else begin
      mean_r <= mean_nxt;
      inv_r  <= inv_nxt;
    end
  end

  assign mean_q8     = mean_r;
  assign inv_std_q16 = inv_r;

endmodule

>>> rtl/gmsn_pipe.sv
// Pixel pipeline: grey conversion, pass counting, sum accumulation and the
// normalize multiply chain with its output register. Uses gmsn_pkg.
`timescale 1ns / 1ps
`include "grey_mean_std_normalizer_macros.svh"
module gmsn_pipe (
  input  logic                          clk,
  input  logic                          rst_n,
  input  gmsn_pkg::in_pkt_t             in_data,
  input  logic                          in_accept,
  input  gmsn_pkg::ctrl_cmd_t           cmd,
  input  logic [gmsn_pkg::MEAN_W-1:0]   mean_q8,
  input  logic [gmsn_pkg::INV_W-1:0]    inv_std_q16,
  input  logic                          out_ready,
  output logic                          out_valid,
  output gmsn_pkg::out_pkt_t            out_data,
  output gmsn_pkg::pipe_sts_t           sts,
  output logic [gmsn_pkg::SUM_W-1:0]    grey_sum,
  output logic [gmsn_pkg::SQ_W-1:0]     square_sum,
  output logic [gmsn_pkg::CNT_W-1:0]    fin_n
);

  logic [gmsn_pkg::CNT_W-1:0] cnt_r, cnt_nxt, cnt_inc;
  logic                       last_calc;
  logic [23:0]                wsum;
  logic [7:0]                 grey;

  logic                       s1_v_r, s1_kind_r, s1_last_r;
  logic [7:0]                 s1_grey_r;
  logic                       s1_go, s1_rdy;

  logic [gmsn_pkg::SUM_W-1:0] gsum_r, gsum_nxt;
  logic [gmsn_pkg::SQ_W-1:0]  sq_r, sq_nxt;
  logic [gmsn_pkg::SUM_W:0]   gsum_add;
  logic [gmsn_pkg::SQ_W:0]    sq_add;
  logic [15:0]                grey_sq;
  logic [gmsn_pkg::CNT_W-1:0] fin_n_r;

  logic [7:0]                 mean_floor, diff;
  logic                       s2_v_r, s2_last_r, s2_rdy, s2_go;
  logic [23:0]                s2_p1_r;
  logic [gmsn_pkg::INV_W-1:0] s2_inv_r;
  logic                       s3_v_r, s3_last_r, s3_rdy, s3_go;
  logic [47:0]                s3_p2_r;
  logic                       out_v_r, out_rdy_int;
  gmsn_pkg::out_pkt_t         out_data_r;

  // grey = weighted sum in Q16, truncated
  assign wsum = 24'(in_data.chan0) * 24'(gmsn_pkg::W0)
              + 24'(in_data.chan1) * 24'(gmsn_pkg::W1)
              + 24'(in_data.chan2) * 24'(gmsn_pkg::W2);
  assign grey = wsum[23:16];

  // pass counter, saturating; a pass ends on frame_end or a full frame
  assign cnt_inc   = (&cnt_r) ? cnt_r : cnt_r + 1'b1;
  assign last_calc = in_data.frame_end || ({1'b0, cnt_inc} >= gmsn_pkg::FRAME_PIXELS);

  always_comb begin
    cnt_nxt = cnt_r;
    if (in_accept) begin
      cnt_nxt = last_calc ? '0 : cnt_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // pixel count of the finished gather pass
  always_ff @(posedge clk) begin
    if (in_accept && !in_data.kind && last_calc) begin
      fin_n_r <= cnt_inc;
    end
  end

  // handshake chain: normalize items move when the next can take
  assign out_rdy_int = !out_v_r || out_ready;
  assign s3_go  = s3_v_r && out_rdy_int;
  assign s3_rdy = !s3_v_r || out_rdy_int;
  assign s2_go  = s2_v_r && s3_rdy;
  assign s2_rdy = !s2_v_r || s3_rdy;
  assign s1_go  = s1_v_r && (!s1_kind_r || s2_rdy);
  assign s1_rdy = !s1_v_r || s1_go;

  assign sts.s1_ready    = s1_rdy;
  assign sts.gather_last = !in_data.kind && last_calc;

  // stage 1: grey register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_rdy) begin
      s1_v_r <= in_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_kind_r <= in_data.kind;
      s1_last_r <= last_calc;
      s1_grey_r <= grey;
    end
  end

  // gather: saturating sum and sum of squares
  assign grey_sq  = 16'(s1_grey_r) * 16'(s1_grey_r);
  assign gsum_add = {1'b0, gsum_r} + 30'(s1_grey_r);
  assign sq_add   = {1'b0, sq_r} + 38'(grey_sq);

  always_comb begin
    gsum_nxt = gsum_r;
    sq_nxt   = sq_r;
    if (cmd.clear_sums) begin
      gsum_nxt = '0;
      sq_nxt   = '0;
    end else if (s1_v_r && !s1_kind_r) begin
      gsum_nxt = gsum_add[gmsn_pkg::SUM_W] ? '1 : gsum_add[gmsn_pkg::SUM_W-1:0];
      sq_nxt   = sq_add[gmsn_pkg::SQ_W] ? '1 : sq_add[gmsn_pkg::SQ_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gsum_r <= '0;
      sq_r   <= '0;
    end else begin
      gsum_r <= gsum_nxt;
      sq_r   <= sq_nxt;
    end
  end

  // stage 2: mean * (grey - floor(mean)), negative differences give zero
  assign mean_floor = mean_q8[15:8];
  assign diff = (s1_grey_r > mean_floor) ? (s1_grey_r - mean_floor) : 8'h00;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_rdy) begin
      s2_v_r <= s1_v_r && s1_kind_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_v_r && s1_kind_r && s2_rdy) begin
      s2_p1_r   <= 24'(mean_q8) * 24'(diff);
      s2_inv_r  <= inv_std_q16;
      s2_last_r <= s1_last_r;
    end
  end

  // stage 3: times the reciprocal deviation
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (s3_rdy) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_go) begin
      s3_p2_r   <= 48'(s2_p1_r) * 48'(s2_inv_r);
      s3_last_r <= s2_last_r;
    end
  end

  // output register: drop 24 fraction bits, clamp to a byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_rdy_int) begin
      out_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_go) begin
      out_data_r.norm_pixel <= (|s3_p2_r[47:32]) ? 8'hFF : s3_p2_r[31:24];
      out_data_r.is_last    <= s3_last_r;
    end
  end

  assign out_valid  = out_v_r;
  assign out_data   = out_data_r;
  assign grey_sum   = gsum_r;
  assign square_sum = sq_r;
  assign fin_n      = fin_n_r;

  `GMSN_ASSERT_NEXT(a_gather_drains, s1_v_r && !s1_kind_r && !in_accept, !s1_v_r)
  `GMSN_ASSERT_NOW(a_clear_no_fold, cmd.clear_sums, !(s1_v_r && !s1_kind_r))
  `GMSN_ASSERT_NEXT(a_last_clears_cnt, in_accept && last_calc, cnt_r == '0)

endmodule

>>> rtl/gmsn_ctrl.sv
// Controller: input gating and the end-of-gather statistics sequence.
// Drives gmsn_stats and gmsn_pipe through commands. Uses gmsn_pkg.
`timescale 1ns / 1ps
`include "grey_mean_std_normalizer_macros.svh"
module gmsn_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  gmsn_pkg::pipe_sts_t  sts,
  output logic                 in_ready,
  output gmsn_pkg::ctrl_cmd_t  cmd
);

  gmsn_pkg::state_t            state_r, state_nxt;
  logic [gmsn_pkg::STEP_W-1:0] step_r, step_nxt;
  logic                        div_end, mul_end, root_end;

  assign div_end  = (step_r == gmsn_pkg::STEP_W'(gmsn_pkg::DIV_STEPS - 1));
  assign mul_end  = (step_r == gmsn_pkg::STEP_W'(gmsn_pkg::MUL_STEPS - 1));
  assign root_end = (step_r == gmsn_pkg::STEP_W'(gmsn_pkg::ROOT_STEPS - 1));

  // state and step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gmsn_pkg::ST_RUN;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt      = state_r;
    step_nxt       = '0;
    in_ready       = 1'b0;
    cmd.op         = gmsn_pkg::OP_IDLE;
    cmd.clear_sums = 1'b0;
    case (state_r)
      gmsn_pkg::ST_RUN: begin
        in_ready = sts.s1_ready;
        if (in_valid && sts.s1_ready && sts.gather_last) begin
          state_nxt = gmsn_pkg::ST_FOLD;
        end
      end
      // last gather pixel folds into the sums
      gmsn_pkg::ST_FOLD: begin
        state_nxt = gmsn_pkg::ST_MEAN_LD;
      end
      gmsn_pkg::ST_MEAN_LD: begin
        cmd.op    = gmsn_pkg::OP_DIV_MEAN_LD;
        state_nxt = gmsn_pkg::ST_MEAN_DIV;
      end
      gmsn_pkg::ST_MEAN_DIV: begin
        cmd.op   = gmsn_pkg::OP_DIV_STEP;
        step_nxt = step_r + 1'b1;
        if (div_end) begin
          step_nxt  = '0;
          state_nxt = gmsn_pkg::ST_MEAN_WR;
        end
      end
      gmsn_pkg::ST_MEAN_WR: begin
        cmd.op    = gmsn_pkg::OP_MEAN_WR;
        state_nxt = gmsn_pkg::ST_MULA_LD;
      end
      gmsn_pkg::ST_MULA_LD: begin
        cmd.op    = gmsn_pkg::OP_MULA_LD;
        state_nxt = gmsn_pkg::ST_MULA_RUN;
      end
      gmsn_pkg::ST_MULA_RUN: begin
        cmd.op   = gmsn_pkg::OP_MUL_STEP;
        step_nxt = step_r + 1'b1;
        if (mul_end) begin
          step_nxt  = '0;
          state_nxt = gmsn_pkg::ST_MULB_LD;
        end
      end
      gmsn_pkg::ST_MULB_LD: begin
        cmd.op    = gmsn_pkg::OP_MULB_LD;
        state_nxt = gmsn_pkg::ST_MULB_RUN;
      end
      gmsn_pkg::ST_MULB_RUN: begin
        cmd.op   = gmsn_pkg::OP_MUL_STEP;
        step_nxt = step_r + 1'b1;
        if (mul_end) begin
          step_nxt  = '0;
          state_nxt = gmsn_pkg::ST_ROOT_LD;
        end
      end
      gmsn_pkg::ST_ROOT_LD: begin
        cmd.op    = gmsn_pkg::OP_ROOT_LD;
        state_nxt = gmsn_pkg::ST_ROOT_RUN;
      end
      gmsn_pkg::ST_ROOT_RUN: begin
        cmd.op   = gmsn_pkg::OP_ROOT_STEP;
        step_nxt = step_r + 1'b1;
        if (root_end) begin
          step_nxt  = '0;
          state_nxt = gmsn_pkg::ST_INV_LD;
        end
      end
      gmsn_pkg::ST_INV_LD: begin
        cmd.op    = gmsn_pkg::OP_DIV_INV_LD;
        state_nxt = gmsn_pkg::ST_INV_DIV;
      end
      gmsn_pkg::ST_INV_DIV: begin
        cmd.op   = gmsn_pkg::OP_DIV_STEP;
        step_nxt = step_r + 1'b1;
        if (div_end) begin
          step_nxt  = '0;
          state_nxt = gmsn_pkg::ST_INV_WR;
        end
      end
      // publish the reciprocal and start a fresh gather
      gmsn_pkg::ST_INV_WR: begin
        cmd.op         = gmsn_pkg::OP_INV_WR;
        cmd.clear_sums = 1'b1;
        state_nxt      = gmsn_pkg::ST_RUN;
      end
      default: begin
        state_nxt = gmsn_pkg::ST_RUN;
      end
    endcase
  end

  `GMSN_ASSERT_NEXT(a_gl_enters_fold, in_valid && in_ready && sts.gather_last,
                    state_r == gmsn_pkg::ST_FOLD && !in_ready)
  `GMSN_ASSERT_NOW(a_busy_blocks, state_r != gmsn_pkg::ST_RUN, !in_ready)
  `GMSN_ASSERT_NOW(a_step_bound, 1'b1, step_r < gmsn_pkg::STEP_W'(gmsn_pkg::DIV_STEPS))

endmodule

>>> rtl/grey_mean_std_normalizer.sv
// Grey conversion with frame mean / standard deviation normalization.
// Top level; instantiates gmsn_ctrl, gmsn_pipe and gmsn_stats, uses gmsn_pkg.
//
// Usage: each frame is streamed twice on the in_ channel (valid/ready).
// Items with kind 0 gather the grey sum and sum of squares and give no
// result; items with kind 1 give one out_ item each, the normalized grey
// byte and an is_last flag. A pass ends on frame_end or after FRAME_PIXELS
// items.
// Throughput: one item per cycle in both passes while in_ready is high; it
// drops during the statistics sequence and on a stall. The end of a gather
// pass starts the statistics sequence (mean division, two shift-add
// products, square root, reciprocal division); in_ready stays low through
// it: the 40-step divider run twice, the 29-step multiplier run twice, the
// 32-step root and eight fold, load and write states. Normalize items pass
// from the grey register via two multiplier stages to the output register.
// Reset: all statistics read zero, so a normalize pass before any gather
// pass yields zeros.
// Stall: with out_ready low the result waits in the output register while
// the three stages behind it fill; in_ready drops once all are full.
`timescale 1ns / 1ps
module grey_mean_std_normalizer (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  gmsn_pkg::in_pkt_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output gmsn_pkg::out_pkt_t  out_data
);

  gmsn_pkg::ctrl_cmd_t         cmd;
  gmsn_pkg::pipe_sts_t         sts;
  logic                        in_accept;
  logic [gmsn_pkg::SUM_W-1:0]  grey_sum;
  logic [gmsn_pkg::SQ_W-1:0]   square_sum;
  logic [gmsn_pkg::CNT_W-1:0]  fin_n;
  logic [gmsn_pkg::MEAN_W-1:0] mean_q8;
  logic [gmsn_pkg::INV_W-1:0]  inv_std_q16;

  assign in_accept = in_valid && in_ready;

  gmsn_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .sts      (sts),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  gmsn_pipe u_pipe (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_data     (in_data),
    .in_accept   (in_accept),
    .cmd         (cmd),
    .mean_q8     (mean_q8),
    .inv_std_q16 (inv_std_q16),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .out_data    (out_data),
    .sts         (sts),
    .grey_sum    (grey_sum),
    .square_sum  (square_sum),
    .fin_n       (fin_n)
  );

  gmsn_stats u_stats (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .grey_sum    (grey_sum),
    .square_sum  (square_sum),
    .fin_n       (fin_n),
    .mean_q8     (mean_q8),
    .inv_std_q16 (inv_std_q16)
  );

endmodule
